/* sv/fpa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and command codes for the fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_MIN      = 4'd4,
        CMD_MAX      = 4'd5,
        CMD_CMP      = 4'd6,
        CMD_INC      = 4'd7,
        CMD_DEC      = 4'd8,
        CMD_TO_INT   = 4'd9,
        CMD_FROM_INT = 4'd10
    } t_cmd;

    // Side information that travels with a word through the divider stages.
    typedef struct packed {
        logic        is_div;
        logic        neg;
        logic        dz;
        logic        gt;
        logic        lt;
        logic        eq;
        logic [31:0] res;
    } t_side;

endpackage
`default_nettype wire

/* sv/fpa_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_front
// Three register stages: capture, multiply and simple ops, scale and prepare
// the divider operands.
// ----------------------------------------------------------------------------
module fpa_front #(
    parameter int FRACTION_BITS = 8,
    parameter int QW            = 32 + FRACTION_BITS
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_adv,
    input  wire                  i_valid,
    input  wire  [3:0]           i_command,
    input  wire  signed [31:0]   i_operand_a,
    input  wire  signed [31:0]   i_operand_b,
    output logic                 o_valid,
    output fpa_pkg::t_side       o_side,
    output logic [31:0]          o_rem,
    output logic [QW-1:0]        o_work,
    output logic [31:0]          o_den
);

    // stage A
    logic               r_va;
    logic [3:0]         r_cmd_a;
    logic signed [31:0] r_a, r_b;

    // stage B
    logic               r_vb;
    logic [3:0]         r_cmd_b;
    logic signed [63:0] r_prod;
    logic [31:0]        r_res_b;
    logic               r_gt_b, r_lt_b, r_eq_b, r_dz_b, r_neg_b;
    logic [31:0]        r_abs_a, r_abs_b;

    logic [31:0]        n_res_b;
    logic signed [63:0] w_bias;
    logic signed [63:0] w_scaled;
    logic               w_is_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_adv) begin
            r_va <= i_valid;
            r_vb <= r_va;
            o_valid <= r_vb;
        end
    end

    always_comb begin
        case (fpa_pkg::t_cmd'(r_cmd_a))
            fpa_pkg::CMD_ADD:      n_res_b = r_a + r_b;
            fpa_pkg::CMD_SUB:      n_res_b = r_a - r_b;
            fpa_pkg::CMD_MIN:      n_res_b = (r_a < r_b) ? r_a : r_b;
            fpa_pkg::CMD_MAX:      n_res_b = (r_a > r_b) ? r_a : r_b;
            fpa_pkg::CMD_INC:      n_res_b = r_a + 32'sd1;
            fpa_pkg::CMD_DEC:      n_res_b = r_a - 32'sd1;
            fpa_pkg::CMD_TO_INT:   n_res_b = r_a >>> FRACTION_BITS;
            fpa_pkg::CMD_FROM_INT: n_res_b = r_a << FRACTION_BITS;
            default:               n_res_b = 32'd0;
        endcase
    end

    // truncate toward zero: bias negative products before the shift
    assign w_bias   = r_prod[63] ? ((64'sd1 <<< FRACTION_BITS) - 64'sd1) : 64'sd0;
    assign w_scaled = (r_prod + w_bias) >>> FRACTION_BITS;
    assign w_is_div = (fpa_pkg::t_cmd'(r_cmd_b) == fpa_pkg::CMD_DIV);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cmd_a <= i_command;
            r_a     <= i_operand_a;
            r_b     <= i_operand_b;

            r_cmd_b <= r_cmd_a;
            r_prod  <= r_a * r_b;
            r_res_b <= n_res_b;
            r_gt_b  <= r_a > r_b;
            r_lt_b  <= r_a < r_b;
            r_eq_b  <= r_a == r_b;
            r_dz_b  <= (fpa_pkg::t_cmd'(r_cmd_a) == fpa_pkg::CMD_DIV) && (r_b == 32'sd0);
            r_neg_b <= r_a[31] ^ r_b[31];
            r_abs_a <= r_a[31] ? 32'(-r_a) : 32'(r_a);
            r_abs_b <= r_b[31] ? 32'(-r_b) : 32'(r_b);

            o_side.is_div <= w_is_div;
            o_side.neg    <= r_neg_b;
            o_side.dz     <= r_dz_b;
            o_side.gt     <= r_gt_b;
            o_side.lt     <= r_lt_b;
            o_side.eq     <= r_eq_b;
            o_side.res    <= (fpa_pkg::t_cmd'(r_cmd_b) == fpa_pkg::CMD_MUL)
                             ? w_scaled[31:0] : r_res_b;
            o_rem         <= 32'd0;
            o_work        <= QW'(r_abs_a) << FRACTION_BITS;
            o_den         <= r_abs_b;
        end
    end

endmodule
`default_nettype wire

/* sv/fpa_div_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_div_stage
// One restoring division step: shift in a dividend bit, try the subtract,
// shift the quotient bit into the work word.
// ----------------------------------------------------------------------------
module fpa_div_stage #(
    parameter int QW = 40
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_adv,
    input  wire                  i_valid,
    input  fpa_pkg::t_side       i_side,
    input  wire  [31:0]          i_rem,
    input  wire  [QW-1:0]        i_work,
    input  wire  [31:0]          i_den,
    output logic                 o_valid,
    output fpa_pkg::t_side       o_side,
    output logic [31:0]          o_rem,
    output logic [QW-1:0]        o_work,
    output logic [31:0]          o_den
);

    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic        w_bit;

    assign w_trial = {i_rem, i_work[QW-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_bit   = !w_diff[32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_side <= i_side;
            o_rem  <= w_bit ? w_diff[31:0] : w_trial[31:0];
            o_work <= {i_work[QW-2:0], w_bit};
            o_den  <= i_den;
        end
    end

endmodule
`default_nettype wire

/* sv/fixed_point_alu_q24_8.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed 32-bit fixed-point ALU, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_command, i_operand_a, i_operand_b.
//   A word is taken on a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_result and four flags; one
//   result word per input word, in order.
//   Path: three front stages, one divider stage per quotient bit
//   (32 + FRACTION_BITS), and the output register; every command takes it.
//   Throughput: one word per cycle unless stalled; the divider is a chain
//   of one-bit restoring stages, so a new word can enter every cycle
//   that the pipe advances.
//   Stall: all stages share one advance enable. When the output register
//   holds a word and i_stall is high, the whole pipe freezes and o_stall
//   rises; nothing is dropped or repeated.
//   Reset: synchronous, active low; clears the valid bits only.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 #(
    parameter int FRACTION_BITS = 8
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  [3:0]         i_command,
    input  wire  signed [31:0] i_operand_a,
    input  wire  signed [31:0] i_operand_b,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [31:0] o_result,
    output logic               o_a_greater,
    output logic               o_a_less,
    output logic               o_a_equal,
    output logic               o_divide_by_zero
);

    localparam int QW = 32 + FRACTION_BITS;

    logic                 w_adv;
    logic                 w_valid [0:QW];
    fpa_pkg::t_side       w_side  [0:QW];
    logic [31:0]          w_rem   [0:QW];
    logic [QW-1:0]        w_work  [0:QW];
    logic [31:0]          w_den   [0:QW];
    logic [QW-1:0]        w_qs;

    // advance whenever the output register is empty or being taken
    assign w_adv   = !o_valid || !i_stall;
    assign o_stall = !w_adv;

    fpa_front #(
        .FRACTION_BITS(FRACTION_BITS),
        .QW           (QW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_valid    (i_valid),
        .i_command  (i_command),
        .i_operand_a(i_operand_a),
        .i_operand_b(i_operand_b),
        .o_valid    (w_valid[0]),
        .o_side     (w_side[0]),
        .o_rem      (w_rem[0]),
        .o_work     (w_work[0]),
        .o_den      (w_den[0])
    );

    // one quotient bit per stage
    for (genvar g = 0; g < QW; g++) begin : g_div
        fpa_div_stage #(.QW(QW)) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (w_adv),
            .i_valid(w_valid[g]),
            .i_side (w_side[g]),
            .i_rem  (w_rem[g]),
            .i_work (w_work[g]),
            .i_den  (w_den[g]),
            .o_valid(w_valid[g+1]),
            .o_side (w_side[g+1]),
            .o_rem  (w_rem[g+1]),
            .o_work (w_work[g+1]),
            .o_den  (w_den[g+1])
        );
    end

    // apply the quotient sign, then wrap to 32 bits
    assign w_qs = w_side[QW].neg ? (-w_work[QW]) : w_work[QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= w_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_side[QW].dz) begin
                o_result <= 32'sd0;
            end else if (w_side[QW].is_div) begin
                o_result <= w_qs[31:0];
            end else begin
                o_result <= w_side[QW].res;
            end
            o_a_greater      <= w_side[QW].gt;
            o_a_less         <= w_side[QW].lt;
            o_a_equal        <= w_side[QW].eq;
            o_divide_by_zero <= w_side[QW].dz;
        end
    end

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> o_result == 32'sd0)
        else $error("divide by zero with nonzero result");

    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_a_greater, o_a_less, o_a_equal}))
        else $error("compare flags not one-hot");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("pipe not frozen under output stall");

endmodule
`default_nettype wire

/* tb/tb_fixed_point_alu_q24_8.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_q24_8
// Self-checking bench for the Q24.8 ALU. A driver sends command and operand
// words from a queue, a monitor checks every result word against a local
// predictor. Idle and stall patterns change from phase to phase.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu_q24_8;

    localparam int FRAC      = 8;
    localparam int LATENCY   = FRAC + 36;
    localparam int N_RANDOM  = 450;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] a;
        logic [31:0] b;
    } t_op;

    typedef struct packed {
        logic [31:0] res;
        logic        gt;
        logic        lt;
        logic        eq;
        logic        dz;
    } t_alu_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic [3:0] i_command = '0;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic o_stall, o_valid;
    logic signed [31:0] o_result;
    logic o_a_greater, o_a_less, o_a_equal, o_divide_by_zero;

    fixed_point_alu_q24_8 #(.FRACTION_BITS(FRAC)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result(o_result), .o_a_greater(o_a_greater), .o_a_less(o_a_less),
        .o_a_equal(o_a_equal), .o_divide_by_zero(o_divide_by_zero)
    );

    always #5 i_clk = ~i_clk;

    t_op      pending_ops[$];
    t_alu_out expected_words[$];
    int       mismatches = 0;
    int       words_checked = 0;
    int       send_idle_pct = 0;   // chance per cycle the driver holds off
    int       recv_stall_pct = 0;  // chance per cycle the monitor stalls
    bit       hold_off_req = 1'b0; // ask for one long receiver stall
    bit       hold_off_done = 1'b0;
    int       hold_off_left = 0;   // cycles of forced stall still to go
    bit       in_taken = 1'b0;     // current input word was taken at the last edge

    // Compute the ALU word for one operation.
    function automatic t_alu_out alu_predict(t_op op);
        t_alu_out o;
        logic signed [31:0] a, b;
        logic signed [63:0] wide;
        a = op.a;
        b = op.b;
        o = '0;
        o.gt = a > b;
        o.lt = a < b;
        o.eq = a == b;
        case (op.cmd)
            fpa_pkg::CMD_ADD:  o.res = a + b;
            fpa_pkg::CMD_SUB:  o.res = a - b;
            fpa_pkg::CMD_MUL: begin
                wide = 64'(a) * 64'(b);
                wide = wide / 64'sd256;     // truncates toward zero
                o.res = wide[31:0];
            end
            fpa_pkg::CMD_DIV: begin
                if (b == 0) begin
                    o.dz = 1'b1;
                end else begin
                    wide = (64'(a) * 64'sd256) / 64'(b);
                    o.res = wide[31:0];
                end
            end
            fpa_pkg::CMD_MIN:      o.res = (a < b) ? a : b;
            fpa_pkg::CMD_MAX:      o.res = (a > b) ? a : b;
            fpa_pkg::CMD_INC:      o.res = a + 1;
            fpa_pkg::CMD_DEC:      o.res = a - 1;
            fpa_pkg::CMD_TO_INT:   o.res = a >>> FRAC;
            fpa_pkg::CMD_FROM_INT: o.res = a << FRAC;
            default:               o.res = '0;  // compare and unused codes
        endcase
        return o;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000 + $urandom_range(0, 3);
            1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2:       return $urandom_range(0, 4) - 2;
            3:       return 32'($signed($urandom_range(0, 8191)) - 4096);
            default: return $urandom;
        endcase
    endfunction

    // Record each input word at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            expected_words.push_back(alu_predict({i_command, i_operand_a, i_operand_b}));
        in_taken <= i_rst_n && i_valid && !o_stall;
    end

    // Driver: offer a word at the falling edge, hold it until it is taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !in_taken) begin
                // hold the stalled word
            end else begin
                if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    t_op op;
                    op = pending_ops.pop_front();
                    i_valid <= 1'b1;
                    i_command <= op.cmd;
                    i_operand_a <= op.a;
                    i_operand_b <= op.b;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random, plus one long forced stretch on request.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_off_left > 0) begin
                i_stall <= 1'b1;
                hold_off_left <= hold_off_left - 1;
            end else if (hold_off_req && !hold_off_done) begin
                i_stall <= 1'b1;
                hold_off_left <= 3 * LATENCY - 1;
                hold_off_done <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Monitor: check each accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_alu_out got, exp_w;
            got = {o_result, o_a_greater, o_a_less, o_a_equal, o_divide_by_zero};
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word %h", got);
            end else begin
                exp_w = expected_words.pop_front();
                words_checked++;
                if (got !== exp_w) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: res exp %h got %h, gt/lt/eq/dz exp %b got %b",
                                 exp_w.res, got.res, exp_w[3:0], got[3:0]);
                end
            end
        end
    end

    task automatic queue_op(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
        pending_ops.push_back('{cmd, a, b});
    endtask

    // Wait until every queued word is sent and every result is back.
    task automatic drain();
        int guard;
        guard = 0;
        while ((pending_ops.size() > 0 || i_valid || expected_words.size() > 0)
               && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    task automatic queue_random(int count);
        int      k;
        logic [3:0] cmd;
        for (k = 0; k < count; k++) begin
            cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                               : 4'($urandom_range(0, 10));
            if ($urandom_range(0, 9) == 0)
                queue_op(cmd, rand_operand(), ($urandom_range(0, 1)) ? 32'd0 : 32'hFFFF_FFFF);
            else if ($urandom_range(0, 9) == 0) begin
                logic [31:0] same;
                same = rand_operand();
                queue_op(cmd, same, same);
            end else
                queue_op(cmd, rand_operand(), rand_operand());
        end
    endtask

    initial begin
        int i;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: every command, several at the operand extremes, equal
        // operands, divide by zero and the unused command codes 11 and 15.
        queue_op(fpa_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
        queue_op(fpa_pkg::CMD_SUB, 32'h8000_0000, 32'h0000_0001);
        queue_op(fpa_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_op(fpa_pkg::CMD_MUL, 32'hFFFF_FF80, 32'h0000_0001);
        queue_op(fpa_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000);
        queue_op(fpa_pkg::CMD_DIV, 32'h0000_0300, 32'h0000_0200);
        queue_op(fpa_pkg::CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_op(fpa_pkg::CMD_DIV, 32'hFFFF_FFFD, 32'h0000_0200);
        queue_op(fpa_pkg::CMD_DIV, 32'h1234_5678, 32'h0000_0000);
        queue_op(fpa_pkg::CMD_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_op(fpa_pkg::CMD_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_op(fpa_pkg::CMD_MIN, 32'h0000_0042, 32'h0000_0042);
        queue_op(fpa_pkg::CMD_MAX, 32'hFFFF_FFF0, 32'hFFFF_FFF0);
        queue_op(fpa_pkg::CMD_CMP, 32'h0000_0001, 32'hFFFF_FFFF);
        queue_op(fpa_pkg::CMD_INC, 32'h7FFF_FFFF, 32'h0);
        queue_op(fpa_pkg::CMD_DEC, 32'h8000_0000, 32'h0);
        queue_op(fpa_pkg::CMD_TO_INT, 32'hFFFF_FF01, 32'h0);
        queue_op(fpa_pkg::CMD_TO_INT, 32'h7FFF_FFFF, 32'h0);
        queue_op(fpa_pkg::CMD_FROM_INT, 32'hFFFF_FFFF, 32'h0);
        queue_op(fpa_pkg::CMD_FROM_INT, 32'h00FF_FFFF, 32'h0);
        queue_op(4'd11, 32'h5, 32'h3);
        queue_op(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // Random phases: none, sender idle, receiver stalling, both.
        for (i = 0; i < 4; i++) begin
            send_idle_pct  = (i == 1) ? 62 : (i == 3) ? 28 : 0;
            recv_stall_pct = (i == 2) ? 62 : (i == 3) ? 28 : 0;
            queue_random(N_RANDOM / 5);
            if (i == 0) begin
                // hold off the receiver long enough to fill the pipe
                hold_off_req = 1'b1;
            end
            drain();   // sender pauses until every result is back
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random(N_RANDOM / 5);
        drain();

        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d result words over all commands and idle/stall mixes.",
                 words_checked);
        if (mismatches == 0 && expected_words.size() == 0 && pending_ops.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d words still expected", mismatches,
                     expected_words.size());
            $display("Verification failed");
        end
        $finish;
    end

    // Time limit for the whole run.
    initial begin
        #5ms;
        $display("Timeout");
        $display("Verification failed");
        $finish;
    end
endmodule
